>>> src/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

	localparam int IdWidth   = 16;
	localparam int TimeWidth = 11;
	localparam int FillWidth = 5;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [IdWidth-1:0]   id;
		logic [TimeWidth-1:0] tm;
	} entry_t;

	localparam int EntryWidth = IdWidth + TimeWidth;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_INS_WR,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} state_t;

endpackage

>>> src/spq_req_if.sv
`timescale 1ns / 1ps
interface spq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] order_id;
	logic [10:0] arrival_minute;

	modport source (output valid, req_type, order_id, arrival_minute, input ready);
	modport sink (input valid, req_type, order_id, arrival_minute, output ready);
endinterface

>>> src/spq_rsp_if.sv
`timescale 1ns / 1ps
interface spq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_order_id;
	logic [10:0] out_arrival_minute;
	logic [4:0]  fill_level;

	modport source (output valid, status, out_order_id, out_arrival_minute, fill_level,
		input ready);
	modport sink (input valid, status, out_order_id, out_arrival_minute, fill_level,
		output ready);
endinterface

>>> src/spq_ram.sv
`timescale 1ns / 1ps
module spq_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/sorted_priority_queue_with_cancel.sv
`timescale 1ns / 1ps
// channel | dir | fields
// req     | in  | req_type, order_id, arrival_minute
// rsp     | out | status, out_order_id, out_arrival_minute, fill_level
//
// one request at a time; entries live in one ram, sorted earliest first
// insert walks down from the tail, moving each later entry back one slot as it goes
// pop and cancel shift the tail up by one; cancel first scans from the head for the id
// all reads and writes go through the single ram port pair
// reset empties the queue at once; a stalled result holds the next finish in ST_DONE
module sorted_priority_queue_with_cancel #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

	state_t state_q, state_d;
	logic [CW-1:0] idx_q, count_q;
	logic [1:0] rtype_q;
	logic [IdWidth-1:0] id_q;
	logic [TimeWidth-1:0] tm_q;
	logic [1:0] rstat_q;
	entry_t res_q;

	logic rsp_valid_q;
	logic [1:0] rsp_status_q;
	entry_t rsp_ent_q;
	logic [FillWidth-1:0] rsp_fill_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;

	logic [CW-1:0] idx_m1;
	logic [CW:0] idx_p1, idx_p2;
	logic later, id_hit, rm_last, sh_last, scan_end, res_load;
	logic [CW+FillWidth-1:0] count_ext;

	spq_ram #(.WIDTH(EntryWidth), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign idx_m1   = idx_q - 1'b1;
	assign idx_p1   = {1'b0, idx_q} + 1'b1;
	assign idx_p2   = {1'b0, idx_q} + 2'd2;
	assign later    = ram_rdata.tm > tm_q;
	assign id_hit   = ram_rdata.id == id_q;
	assign rm_last  = idx_p1 >= {1'b0, count_q};
	assign sh_last  = idx_p2 >= {1'b0, count_q};
	assign scan_end = idx_p1 == {1'b0, count_q};
	assign res_load = !rsp_valid_q || rsp.ready;
	assign count_ext = {{FillWidth{1'b0}}, count_q};

	assign req.ready = state_q == ST_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req_type_t'(req.req_type))
						REQ_INSERT: state_d = (count_q == '0 || count_q >= DepthC) ?
							ST_DONE : ST_RD;
						REQ_POP, REQ_CANCEL: state_d = (count_q == '0) ? ST_DONE : ST_RD;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RD: state_d = ST_CHK;
			ST_CHK: begin
				case (req_type_t'(rtype_q))
					REQ_INSERT: state_d = later ? ((idx_m1 == '0) ? ST_INS_WR : ST_RD) : ST_DONE;
					REQ_CANCEL: begin
						if (id_hit) begin
							state_d = rm_last ? ST_DONE : ST_SH_RD;
						end else begin
							state_d = scan_end ? ST_DONE : ST_RD;
						end
					end
					default: state_d = rm_last ? ST_DONE : ST_SH_RD;
				endcase
			end
			ST_INS_WR: state_d = ST_DONE;
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = sh_last ? ST_DONE : ST_SH_RD;
			ST_DONE: state_d = res_load ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				// empty queue insert goes straight to slot zero
				ram_we    = req.valid && req_type_t'(req.req_type) == REQ_INSERT &&
					count_q == '0;
				ram_waddr = '0;
				ram_wdata = '{id: req.order_id, tm: req.arrival_minute};
			end
			ST_RD: begin
				if (req_type_t'(rtype_q) == REQ_INSERT) begin
					ram_raddr = idx_m1[AW-1:0];
				end
			end
			ST_CHK: begin
				if (req_type_t'(rtype_q) == REQ_INSERT) begin
					ram_we    = 1'b1;
					ram_wdata = later ? ram_rdata : '{id: id_q, tm: tm_q};
				end
			end
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_wdata = '{id: id_q, tm: tm_q};
			end
			ST_SH_RD: ram_raddr = idx_p1[AW-1:0];
			ST_SH_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rtype_q <= req.req_type;
						id_q    <= req.order_id;
						tm_q    <= req.arrival_minute;
						res_q   <= '0;
						case (req_type_t'(req.req_type))
							REQ_INSERT: begin
								rstat_q <= (count_q >= DepthC) ? STAT_FULL : STAT_OK;
								idx_q   <= count_q;
								if (count_q == '0) count_q <= count_q + 1'b1;
							end
							REQ_POP: begin
								rstat_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
								idx_q   <= '0;
							end
							REQ_CANCEL: begin
								rstat_q <= (count_q == '0) ? STAT_NOTFOUND : STAT_OK;
								idx_q   <= '0;
							end
							default: begin
								rstat_q <= STAT_OK;
								idx_q   <= '0;
							end
						endcase
					end
				end
				ST_CHK: begin
					case (req_type_t'(rtype_q))
						REQ_INSERT: begin
							if (later) begin
								idx_q <= idx_m1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						REQ_CANCEL: begin
							if (id_hit) begin
								res_q <= ram_rdata;
								if (rm_last) count_q <= count_q - 1'b1;
							end else if (scan_end) begin
								rstat_q <= STAT_NOTFOUND;
							end else begin
								idx_q <= idx_p1[CW-1:0];
							end
						end
						default: begin
							res_q <= ram_rdata;
							if (rm_last) count_q <= count_q - 1'b1;
						end
					endcase
				end
				ST_INS_WR: count_q <= count_q + 1'b1;
				ST_SH_WR: begin
					idx_q <= idx_p1[CW-1:0];
					if (sh_last) count_q <= count_q - 1'b1;
				end
				ST_DONE: begin
					if (res_load) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= rstat_q;
						rsp_ent_q    <= res_q;
						rsp_fill_q   <= count_ext[FillWidth-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = rsp_status_q;
	assign rsp.out_order_id       = rsp_ent_q.id;
	assign rsp.out_arrival_minute = rsp_ent_q.tm;
	assign rsp.fill_level         = rsp_fill_q;
endmodule

>>> dv/sorted_priority_queue_with_cancel_tb.sv
`timescale 1ns / 1ps
module sorted_priority_queue_with_cancel_tb;
	import spq_pkg::*;

	localparam int Depth = 16;
	localparam int MaxCycles = 400000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] oid;
		logic [10:0] tm;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] oid;
		logic [10:0] tm;
		logic [4:0]  fill;
	} answer_t;

	// directed row: request plus an answer that is checked only where one is typed in
	typedef struct packed {
		request_t    rq;
		logic        has_answer;
		answer_t     ans;
	} row_t;

	logic clk;
	logic arst_n;
	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue_with_cancel #(.QUEUE_DEPTH(Depth)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// queue shadow, earliest first
	logic [10:0] held_tm [$];
	logic [15:0] held_id [$];
	answer_t pending_answers [$];
	answer_t typed_answers [$];
	logic typed_flags [$];

	int mismatches;
	int answers_seen;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	function automatic answer_t order_book_step(request_t rq);
		answer_t a;
		int pos;
		a = '0;
		a.status = STAT_OK;
		case (rq.kind)
			REQ_INSERT: begin
				if (held_tm.size() >= Depth) begin
					a.status = STAT_FULL;
				end else begin
					pos = 0;
					while (pos < held_tm.size() && held_tm[pos] <= rq.tm) pos++;
					held_tm.insert(pos, rq.tm);
					held_id.insert(pos, rq.oid);
				end
			end
			REQ_POP: begin
				if (held_tm.size() == 0) begin
					a.status = STAT_EMPTY;
				end else begin
					a.oid = held_id.pop_front();
					a.tm = held_tm.pop_front();
				end
			end
			REQ_CANCEL: begin
				pos = -1;
				for (int i = 0; i < held_id.size(); i++)
					if (pos < 0 && held_id[i] == rq.oid) pos = i;
				if (pos < 0) begin
					a.status = STAT_NOTFOUND;
				end else begin
					a.oid = held_id[pos];
					a.tm = held_tm[pos];
					held_id.delete(pos);
					held_tm.delete(pos);
				end
			end
			default: ;
		endcase
		a.fill = 5'(held_tm.size());
		return a;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MaxCycles) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("sorted_priority_queue_with_cancel_tb NOT OK");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else begin
			rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		answer_t got, want;
		logic typed;
		answer_t typed_ans;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.status, rsp.out_order_id, rsp.out_arrival_minute, rsp.fill_level};
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				want = pending_answers.pop_front();
				typed = typed_flags.pop_front();
				typed_ans = typed_answers.pop_front();
				if (typed && typed_ans != want) want = typed_ans;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d id %h/%h tm %0d/%0d fill %0d/%0d",
							want.status, got.status, want.oid, got.oid,
							want.tm, got.tm, want.fill, got.fill);
				end
			end
		end
	end

	task automatic send(request_t rq, logic typed, answer_t ans);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		{req.req_type, req.order_id, req.arrival_minute} <= rq;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_answers.push_back(order_book_step(rq));
		typed_flags.push_back(typed);
		typed_answers.push_back(ans);
	endtask

	task automatic drain;
		req.valid <= 0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	function automatic request_t random_request(int fill_bias);
		request_t rq;
		int pick;
		pick = $urandom_range(99);
		rq.oid = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(31));
		rq.tm = ($urandom_range(9) == 0) ? 11'($urandom()) : 11'($urandom_range(1439));
		if (pick < fill_bias) rq.kind = REQ_INSERT;
		else if (pick < fill_bias + (96 - fill_bias) / 2) rq.kind = REQ_POP;
		else if (pick < 97) rq.kind = REQ_CANCEL;
		else rq.kind = REQ_NONE;
		// aim cancels at held ids most of the time
		if (rq.kind == REQ_CANCEL && held_id.size() != 0 && $urandom_range(3) != 0)
			rq.oid = held_id[$urandom_range(held_id.size() - 1)];
		return rq;
	endfunction

	row_t rows [$];

	initial begin
		row_t r;
		request_t rq;
		answer_t none;
		mismatches = 0;
		answers_seen = 0;
		cycle_count = 0;
		hold_off = 0;
		send_idle_pct = 6;
		recv_idle_pct = 85;
		none = '0;
		req.valid = 0;
		req.req_type = REQ_NONE;
		req.order_id = 0;
		req.arrival_minute = 0;

		// directed: empty errors, extremes, ties, duplicates, full, unused code
		rows.push_back('{'{REQ_POP, 16'h0, 11'd0}, 1, '{STAT_EMPTY, 16'h0, 11'd0, 5'd0}});
		rows.push_back('{'{REQ_CANCEL, 16'hffff, 11'd0}, 1,
			'{STAT_NOTFOUND, 16'h0, 11'd0, 5'd0}});
		rows.push_back('{'{REQ_NONE, 16'hffff, 11'h7ff}, 1, '{STAT_OK, 16'h0, 11'd0, 5'd0}});
		rows.push_back('{'{REQ_INSERT, 16'hffff, 11'h7ff}, 0, none});
		rows.push_back('{'{REQ_INSERT, 16'h0000, 11'd0}, 0, none});
		rows.push_back('{'{REQ_INSERT, 16'h0001, 11'd1439}, 0, none});
		rows.push_back('{'{REQ_INSERT, 16'h0002, 11'd1439}, 0, none});
		rows.push_back('{'{REQ_INSERT, 16'h0001, 11'd700}, 0, none});
		rows.push_back('{'{REQ_CANCEL, 16'h0001, 11'd0}, 0, none});
		rows.push_back('{'{REQ_POP, 16'h1234, 11'd5}, 0, none});
		for (int i = 0; i < 13; i++)
			rows.push_back('{'{REQ_INSERT, 16'(i * 4097), 11'(i * 150)}, 0, none});
		rows.push_back('{'{REQ_INSERT, 16'h5555, 11'd3}, 1, '{STAT_FULL, 16'h0, 11'd0, 5'd16}});
		rows.push_back('{'{REQ_NONE, 16'h0, 11'd0}, 1, '{STAT_OK, 16'h0, 11'd0, 5'd16}});

		@(posedge arst_n);
		@(posedge clk);
		foreach (rows[i]) send(rows[i].rq, rows[i].has_answer, rows[i].ans);
		drain();
		// empty it again
		for (int i = 0; i < 17; i++) send('{REQ_POP, 16'h0, 11'd0}, 0, none);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 85 : 0;
			recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 6 : 0;
			for (int n = 0; n < 500; n++) begin
				// swing between filling and draining so both ends get hit
				rq = random_request(((n / 60) % 2 == 0) ? 70 : 25);
				send(rq, 0, none);
				if (phase == 2 && n == 200) begin
					hold_off = 1;
					fork
						begin
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				if (n == 400) drain();
			end
		end
		drain();
		repeat (2 * Depth + 20) @(posedge clk);
		$display("covered %0d requests incl. full, empty, missing-id and tie cases", answers_seen);
		$display("with sender and receiver stalls, a long receive hold-off and a drained pause");
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("sorted_priority_queue_with_cancel_tb OK");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, pending_answers.size());
			$display("sorted_priority_queue_with_cancel_tb NOT OK");
		end
		$finish;
	end

endmodule
